>>> rtl/pcrc_pkg.sv
// Shared types, register indexes and helpers for the point cloud crop transform.
`timescale 1ns / 1ps
package pcrc_pkg;

	// One point, x in the low bits so that the stream word maps directly.
	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} pt_t;

	// Rotation matrix element in Q7.28 with headroom for non-unit quaternions.
	typedef logic signed [34:0] mel_t;
	typedef mel_t [8:0] mtx_t;

	// Rounded coordinate before saturation.
	typedef logic signed [23:0] rb_t;
	typedef rb_t [2:0] rb3_t;

	localparam logic [2:0] REG_ROBOT_ROT   = 3'd0;
	localparam logic [2:0] REG_ROBOT_TRANS = 3'd1;
	localparam logic [2:0] REG_MAP_ROT     = 3'd2;
	localparam logic [2:0] REG_MAP_TRANS   = 3'd3;
	localparam logic [2:0] REG_BOX_XY      = 3'd4;
	localparam logic [2:0] REG_BOX_Z       = 3'd5;
	localparam logic [2:0] REG_CLEARANCE   = 3'd6;

	function automatic logic signed [15:0] sat16(input rb_t v);
		logic signed [15:0] r;
		if (v > 24'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -24'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/point_cloud_roi_crop_transform.sv
// Path: delay stages, robot transform, box and clearance stages, queue, map transform, output.
// Throughput: one item per cycle unless stalled; each transform has its own multipliers,
// one product per matrix element per cycle, so front and back each take a point per cycle.
// Stalls on the output fill the kept-point queue before the input is held off.
// Reset: asynchronous, active low; registers return to identity transforms, a box holding
// only the origin and a 450 mm clearance; all pipelines and the queue come up empty.
`timescale 1ns / 1ps
module point_cloud_roi_crop_transform #(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // x_mm [15:0], y_mm [31:16], z_mm [47:32]
	input  logic        s_tuser,   // point_valid [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // map_x_mm [15:0], map_y_mm [31:16], map_z_mm [47:32]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	logic [63:0] robot_rot_q, map_rot_q, box_xy_q;
	logic [47:0] robot_trans_q, map_trans_q;
	logic [31:0] box_z_q;
	logic [14:0] clearance_q;
	logic [29:0] clr2_q;

	pcrc_pkg::mtx_t robot_mtx, map_mtx;
	logic           q_push, q_pop, q_full, q_empty;
	pcrc_pkg::pt_t  q_in_pt, q_out_pt, m_pt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_rot_q   <= 64'd16384;
			robot_trans_q <= '0;
			map_rot_q     <= 64'd16384;
			map_trans_q   <= '0;
			box_xy_q      <= '0;
			box_z_q       <= '0;
			clearance_q   <= 15'd450;
		end else if (cfg_we) begin
			case (cfg_index)
				pcrc_pkg::REG_ROBOT_ROT:   robot_rot_q   <= cfg_wdata;
				pcrc_pkg::REG_ROBOT_TRANS: robot_trans_q <= cfg_wdata[47:0];
				pcrc_pkg::REG_MAP_ROT:     map_rot_q     <= cfg_wdata;
				pcrc_pkg::REG_MAP_TRANS:   map_trans_q   <= cfg_wdata[47:0];
				pcrc_pkg::REG_BOX_XY:      box_xy_q      <= cfg_wdata;
				pcrc_pkg::REG_BOX_Z:       box_z_q       <= cfg_wdata[31:0];
				pcrc_pkg::REG_CLEARANCE:   clearance_q   <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		clr2_q <= clearance_q * clearance_q;
	end

	pcrc_rot_matrix u_robot_mtx (
		.clk   (clk),
		.rot   (robot_rot_q),
		.mtx_q (robot_mtx)
	);

	pcrc_rot_matrix u_map_mtx (
		.clk   (clk),
		.rot   (map_rot_q),
		.mtx_q (map_mtx)
	);

	pcrc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_pt     (pcrc_pkg::pt_t'(s_tdata)),
		.s_tuser  (s_tuser),
		.mtx      (robot_mtx),
		.trans    (robot_trans_q),
		.box_xy   (box_xy_q),
		.box_z    (box_z_q),
		.clr2     (clr2_q),
		.q_full   (q_full),
		.push     (q_push),
		.push_pt  (q_in_pt)
	);

	pcrc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_pt (q_in_pt),
		.full    (q_full),
		.pop     (q_pop),
		.pop_pt  (q_out_pt),
		.empty   (q_empty)
	);

	pcrc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop      (q_pop),
		.q_pt     (q_out_pt),
		.mtx      (map_mtx),
		.trans    (map_trans_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_pt     (m_pt)
	);

	assign m_tdata = 48'(m_pt);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("kept point pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from an empty queue");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_full)
		else $error("input held off while the queue has room");
`endif

endmodule

>>> rtl/pcrc_rot_matrix.sv
// Builds the Q7.28 rotation matrix from a packed Q2.14 quaternion in two register stages.
`timescale 1ns / 1ps
module pcrc_rot_matrix (
	input  logic             clk,
	input  logic [63:0]      rot,
	output pcrc_pkg::mtx_t   mtx_q
);

	localparam pcrc_pkg::mel_t ONE = 35'sd268435456;

	logic signed [15:0] w, x, y, z;
	logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;

	assign w = rot[15:0];
	assign x = rot[31:16];
	assign y = rot[47:32];
	assign z = rot[63:48];

	// Twice the sum or difference of two products, in matrix element width.
	function automatic pcrc_pkg::mel_t dbl(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic sub);
		pcrc_pkg::mel_t ae, be, s;
		ae = {{3{a[31]}}, a};
		be = {{3{b[31]}}, b};
		s = sub ? (ae - be) : (ae + be);
		return s <<< 1;
	endfunction

	always_ff @(posedge clk) begin
		xx_q <= x * x;
		yy_q <= y * y;
		zz_q <= z * z;
		xy_q <= x * y;
		xz_q <= x * z;
		yz_q <= y * z;
		wx_q <= w * x;
		wy_q <= w * y;
		wz_q <= w * z;
	end

	always_ff @(posedge clk) begin
		mtx_q[0] <= ONE - dbl(yy_q, zz_q, 1'b0);
		mtx_q[1] <= dbl(xy_q, wz_q, 1'b1);
		mtx_q[2] <= dbl(xz_q, wy_q, 1'b0);
		mtx_q[3] <= dbl(xy_q, wz_q, 1'b0);
		mtx_q[4] <= ONE - dbl(xx_q, zz_q, 1'b0);
		mtx_q[5] <= dbl(yz_q, wx_q, 1'b1);
		mtx_q[6] <= dbl(xz_q, wy_q, 1'b1);
		mtx_q[7] <= dbl(yz_q, wx_q, 1'b0);
		mtx_q[8] <= ONE - dbl(xx_q, yy_q, 1'b0);
	end

endmodule

>>> rtl/pcrc_xform.sv
// Two-stage rigid transform: nine products, then row sums with translation and rounding.
`timescale 1ns / 1ps
module pcrc_xform (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  pcrc_pkg::pt_t    in_pt,
	input  pcrc_pkg::mtx_t   mtx,
	input  logic [47:0]      trans,
	output logic             out_vld,
	output pcrc_pkg::pt_t    out_pt,
	output pcrc_pkg::rb3_t   out_rb
);

	localparam logic [51:0] HALF = 52'd134217728;

	logic signed [50:0] prod_s1 [9];
	logic               vld_s1, vld_s2;
	pcrc_pkg::pt_t      pt_s1, pt_s2;
	logic [51:0]        acc_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= in_pt;
			pt_s2 <= pt_s1;
			for (int i = 0; i < 3; i++) begin
				prod_s1[3*i]   <= $signed(mtx[3*i])   * in_pt.x;
				prod_s1[3*i+1] <= $signed(mtx[3*i+1]) * in_pt.y;
				prod_s1[3*i+2] <= $signed(mtx[3*i+2]) * in_pt.z;
			end
			// Adding one half before the arithmetic shift rounds halves upward.
			for (int i = 0; i < 3; i++) begin
				acc_s2[i] <= 52'(prod_s1[3*i]) + 52'(prod_s1[3*i+1]) + 52'(prod_s1[3*i+2])
					+ {{8{trans[16*i+15]}}, trans[16*i +: 16], 28'd0} + HALF;
			end
		end
	end

	assign out_vld = vld_s2;
	assign out_pt  = pt_s2;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_rb[i] = acc_s2[i][51:28];
		end
	end

endmodule

>>> rtl/pcrc_front.sv
// Front end: accepts points, moves them to the robot frame and decides which to keep.
`timescale 1ns / 1ps
module pcrc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  pcrc_pkg::pt_t    s_pt,
	input  logic             s_tuser,
	input  pcrc_pkg::mtx_t   mtx,
	input  logic [47:0]      trans,
	input  logic [63:0]      box_xy,
	input  logic [31:0]      box_z,
	input  logic [29:0]      clr2,
	input  logic             q_full,
	output logic             push,
	output pcrc_pkg::pt_t    push_pt
);

	logic               en;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	pcrc_pkg::pt_t      pt_s1, pt_s2, pt_s3, pt_s4, pt_s5;
	logic               x_vld;
	pcrc_pkg::pt_t      x_pt;
	pcrc_pkg::rb3_t     x_rb;
	logic               inbox;
	logic               inbox_s4, inbox_s5;
	pcrc_pkg::rb_t      rbx_s4, rby_s4;
	logic signed [47:0] sqx_s5, sqy_s5;
	logic               keep;
	pcrc_pkg::rb_t      xmin, xmax, ymin, ymax, zmin, zmax;

	assign xmin = 24'($signed(box_xy[15:0]));
	assign xmax = 24'($signed(box_xy[31:16]));
	assign ymin = 24'($signed(box_xy[47:32]));
	assign ymax = 24'($signed(box_xy[63:48]));
	assign zmin = 24'($signed(box_z[15:0]));
	assign zmax = 24'($signed(box_z[31:16]));

	assign keep = vld_s5 && inbox_s5
		&& ((49'(sqx_s5) + 49'(sqy_s5)) > {19'd0, clr2});
	assign en       = !(keep && q_full);
	assign s_tready = en;
	assign push     = keep && !q_full;
	assign push_pt  = pt_s5;

	// Three plain delay stages give the matrix time to settle after a register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid && s_tuser;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= x_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= s_pt;
			pt_s2 <= pt_s1;
			pt_s3 <= pt_s2;
		end
	end

	pcrc_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.in_pt   (pt_s3),
		.mtx     (mtx),
		.trans   (trans),
		.out_vld (x_vld),
		.out_pt  (x_pt),
		.out_rb  (x_rb)
	);

	assign inbox = (x_rb[0] >= xmin) && (x_rb[0] <= xmax)
		&& (x_rb[1] >= ymin) && (x_rb[1] <= ymax)
		&& (x_rb[2] >= zmin) && (x_rb[2] <= zmax);

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s4    <= x_pt;
			inbox_s4 <= inbox;
			rbx_s4   <= x_rb[0];
			rby_s4   <= x_rb[1];
			pt_s5    <= pt_s4;
			inbox_s5 <= inbox_s4;
			sqx_s5   <= rbx_s4 * rbx_s4;
			sqy_s5   <= rby_s4 * rby_s4;
		end
	end

endmodule

>>> rtl/pcrc_queue.sv
// Short queue of kept points between the front and back ends.
`timescale 1ns / 1ps
module pcrc_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcrc_pkg::pt_t    push_pt,
	output logic             full,
	input  logic             pop,
	output pcrc_pkg::pt_t    pop_pt,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pcrc_pkg::pt_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign pop_pt = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/pcrc_back.sv
// Back end: takes kept points from the queue, moves them to the map frame and saturates.
`timescale 1ns / 1ps
module pcrc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	output logic             pop,
	input  pcrc_pkg::pt_t    q_pt,
	input  pcrc_pkg::mtx_t   mtx,
	input  logic [47:0]      trans,
	output logic             m_tvalid,
	input  logic             m_tready,
	output pcrc_pkg::pt_t    m_pt
);

	logic           en;
	logic           vld_s1;
	pcrc_pkg::pt_t  pt_s1;
	logic           x_vld;
	pcrc_pkg::pt_t  x_pt;
	pcrc_pkg::rb3_t x_rb;
	logic           out_vld_q;
	pcrc_pkg::pt_t  out_pt_q;

	assign en       = !out_vld_q || m_tready;
	assign pop      = en && !q_empty;
	assign m_tvalid = out_vld_q;
	assign m_pt     = out_pt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= !q_empty;
			out_vld_q <= x_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1      <= q_pt;
			out_pt_q.x <= pcrc_pkg::sat16(x_rb[0]);
			out_pt_q.y <= pcrc_pkg::sat16(x_rb[1]);
			out_pt_q.z <= pcrc_pkg::sat16(x_rb[2]);
		end
	end

	pcrc_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.in_pt   (pt_s1),
		.mtx     (mtx),
		.trans   (trans),
		.out_vld (x_vld),
		.out_pt  (x_pt),
		.out_rb  (x_rb)
	);

endmodule

>>> test/tb_point_cloud_roi_crop_transform.sv
// Testbench for the point cloud crop box filter with its robot and map transforms.
`timescale 1ns / 1ps
module tb_point_cloud_roi_crop_transform;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} map_pt_t;

	// Register index that the block does not decode.
	localparam logic [2:0] REG_NONE = 3'd7;
	localparam int EXP_DEPTH = 4096;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // x_mm [15:0], y_mm [31:16], z_mm [47:32]
	logic        s_tuser = 1'b0; // point_valid [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // map_x_mm [15:0], map_y_mm [31:16], map_z_mm [47:32]
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_wdata = '0;

	// Shadow copy of the configuration registers.
	logic [63:0] robot_rot, map_rot, box_xy;
	logic [47:0] robot_trans, map_trans;
	logic [31:0] box_z;
	logic [14:0] clearance;

	// Expected map points in order, as a ring with free-running write and read counts.
	map_pt_t exp_pts [EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	point_cloud_roi_crop_transform uut (.*);

	always #2 clk = ~clk;

	function automatic longint lane(input logic [63:0] r, input int k);
		return longint'($signed(r[16*k +: 16]));
	endfunction

	function automatic longint round_mm(input longint v);
		return (v + (64'sd1 <<< 27)) >>> 28;
	endfunction

	// Rotates by a Q2.14 quaternion and adds a millimetre offset, unsaturated.
	task automatic rotate_shift(input logic [63:0] q, input logic [47:0] t,
			input longint p[3], output longint r[3]);
		longint w, x, y, z;
		longint m[3][3];
		w = lane(q, 0); x = lane(q, 1); y = lane(q, 2); z = lane(q, 3);
		m[0][0] = (64'sd1 <<< 28) - 2 * (y*y + z*z);
		m[0][1] = 2 * (x*y - w*z);
		m[0][2] = 2 * (x*z + w*y);
		m[1][0] = 2 * (x*y + w*z);
		m[1][1] = (64'sd1 <<< 28) - 2 * (x*x + z*z);
		m[1][2] = 2 * (y*z - w*x);
		m[2][0] = 2 * (x*z - w*y);
		m[2][1] = 2 * (y*z + w*x);
		m[2][2] = (64'sd1 <<< 28) - 2 * (x*x + y*y);
		for (int i = 0; i < 3; i++)
			r[i] = round_mm(m[i][0]*p[0] + m[i][1]*p[1] + m[i][2]*p[2]
				+ lane({16'd0, t}, i) * (64'sd1 <<< 28));
	endtask

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	task automatic predict_crop(input logic [47:0] d, input logic ok);
		longint p[3], rb[3], mp[3], c;
		map_pt_t e;
		if (!ok) return;
		for (int i = 0; i < 3; i++) p[i] = longint'($signed(d[16*i +: 16]));
		rotate_shift(robot_rot, robot_trans, p, rb);
		if (rb[0] < lane(box_xy, 0) || rb[0] > lane(box_xy, 1) ||
			rb[1] < lane(box_xy, 2) || rb[1] > lane(box_xy, 3)) return;
		if (rb[2] < lane(box_z, 0) || rb[2] > lane(box_z, 1)) return;
		c = clearance;
		if (rb[0]*rb[0] + rb[1]*rb[1] <= c*c) return;
		rotate_shift(map_rot, map_trans, p, mp);
		e.x = clip16(mp[0]); e.y = clip16(mp[1]); e.z = clip16(mp[2]);
		exp_pts[exp_wr % EXP_DEPTH] = e;
		exp_wr++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			pcrc_pkg::REG_ROBOT_ROT:   robot_rot = val;
			pcrc_pkg::REG_ROBOT_TRANS: robot_trans = val[47:0];
			pcrc_pkg::REG_MAP_ROT:     map_rot = val;
			pcrc_pkg::REG_MAP_TRANS:   map_trans = val[47:0];
			pcrc_pkg::REG_BOX_XY:      box_xy = val;
			pcrc_pkg::REG_BOX_Z:       box_z = val[31:0];
			pcrc_pkg::REG_CLEARANCE:   clearance = val[14:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Called at a rising edge and returns at the accept edge, so the next item can be
	// driven at that same edge and items follow with no gap.
	task automatic send_point(input logic [47:0] d, input logic ok);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= ok;
		predict_crop(d, ok);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain;
		int n = 0;
		s_tvalid <= 1'b0;
		while (exp_wr != exp_rd && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (30) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
		if (m_tvalid && m_tready) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: expected no point, got %h", $time, m_tdata);
				errors++;
			end else begin
				map_pt_t e;
				e = exp_pts[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (m_tdata !== {e.z, e.y, e.x}) begin
					$display("%0t: map point expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
						$time, e.x, e.y, e.z, $signed(m_tdata[15:0]),
						$signed(m_tdata[31:16]), $signed(m_tdata[47:32]));
					errors++;
				end
			end
		end
	end

	function automatic logic [47:0] rand_pt(input int span);
		logic [47:0] d;
		for (int i = 0; i < 3; i++)
			d[16*i +: 16] = 16'($signed($urandom_range(2*span)) - span);
		return d;
	endfunction

	function automatic logic [63:0] rand_quat;
		// Mostly near-unit rotations about z, sometimes arbitrary halves.
		if ($urandom_range(3) == 0) return {$urandom, $urandom};
		return {16'($urandom_range(12000)) - 16'd6000, 16'($urandom_range(600)),
			16'($urandom_range(600)), 16'd15000 + 16'($urandom_range(1384))};
	endfunction

	task automatic test_defaults;
		// Reset box is a single point at the origin, inside the clearance: nothing passes.
		send_point('0, 1'b1);
		send_point(48'h7FFF_8000_7FFF, 1'b1);
		drain();
	endtask

	task automatic test_directed;
		write_reg(pcrc_pkg::REG_BOX_XY, {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
		write_reg(pcrc_pkg::REG_BOX_Z, {16'sh7FFF, 16'sh8000});
		write_reg(pcrc_pkg::REG_CLEARANCE, 64'd100);
		write_reg(REG_NONE, 64'hFFFF); // unused index, must be ignored
		send_point({16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b1);
		send_point({16'sh8000, 16'sh8000, 16'sh8000}, 1'b1);
		send_point({16'sh0, 16'sh0, 16'sh7FFF}, 1'b0);
		send_point({16'sh0, 16'sh0, 16'sd100}, 1'b1);   // on the clearance edge
		send_point({16'sh0, 16'sh0, 16'sd101}, 1'b1);
		send_point({16'sh0, 16'sd60, 16'sd80}, 1'b1);   // distance exactly 100
		send_point({16'sh1234, 16'shFFFF, 16'sh5555}, 1'b1);
		drain();
		write_reg(pcrc_pkg::REG_BOX_XY, {16'sd500, -16'sd500, 16'sd500, -16'sd500});
		write_reg(pcrc_pkg::REG_BOX_Z, {16'sd50, -16'sd50});
		write_reg(pcrc_pkg::REG_CLEARANCE, 64'hFFFF_0000);
		send_point({16'sd50, 16'sd0, 16'sd500}, 1'b1);  // corner bounds are inside
		send_point({-16'sd50, -16'sd500, -16'sd500}, 1'b1);
		send_point({16'sd51, 16'sd0, 16'sd500}, 1'b1);
		send_point({16'sd0, 16'sd0, 16'sd501}, 1'b1);
		drain();
		// Empty box: minimum above maximum.
		write_reg(pcrc_pkg::REG_BOX_XY, {16'sd0, 16'sd10, 16'sd100, 16'sd200});
		send_point({16'sd0, 16'sd5, 16'sd300}, 1'b1);
		send_point({16'sd0, 16'sd5, 16'sd150}, 1'b1);
		drain();
		// Large non-unit quaternions and offsets that saturate the map frame.
		write_reg(pcrc_pkg::REG_BOX_XY, {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
		write_reg(pcrc_pkg::REG_CLEARANCE, 64'd0);
		write_reg(pcrc_pkg::REG_ROBOT_ROT, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
		write_reg(pcrc_pkg::REG_ROBOT_TRANS, 64'hFFFF_7FFF_8000_7FFF);
		write_reg(pcrc_pkg::REG_MAP_ROT, {16'h8000, 16'h8000, 16'h8000, 16'h8000});
		write_reg(pcrc_pkg::REG_MAP_TRANS, 64'h0000_8000_7FFF_8000);
		send_point({16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b1);
		send_point({16'sd1, 16'sd2, 16'sd3}, 1'b1);
		send_point({16'sh0, 16'sh0, 16'sh0}, 1'b1);
		drain();
	endtask

	task automatic random_phase(input int items, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		write_reg(pcrc_pkg::REG_ROBOT_ROT, rand_quat());
		write_reg(pcrc_pkg::REG_MAP_ROT, rand_quat());
		write_reg(pcrc_pkg::REG_ROBOT_TRANS, {$urandom, $urandom});
		write_reg(pcrc_pkg::REG_MAP_TRANS, {$urandom, $urandom});
		write_reg(pcrc_pkg::REG_BOX_XY, {16'sd30000 - 16'($urandom_range(20000)),
			-16'sd30000 + 16'($urandom_range(20000)),
			16'sd30000 - 16'($urandom_range(20000)),
			-16'sd30000 + 16'($urandom_range(20000))});
		write_reg(pcrc_pkg::REG_BOX_Z, {16'sd32000 - 16'($urandom_range(10000)),
			-16'sd32000 + 16'($urandom_range(10000))});
		write_reg(pcrc_pkg::REG_CLEARANCE, 64'($urandom_range(3000)));
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(9) == 0)
				send_point(48'({$urandom, $urandom}), 1'($urandom_range(1)));
			else
				send_point(rand_pt($urandom_range(1) ? 32767 : 8000),
					$urandom_range(15) != 0);
		end
		drain();
	endtask

	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// Identity robot frame, full box and no clearance, so nearly every point is kept.
		write_reg(pcrc_pkg::REG_ROBOT_ROT, 64'd16384);
		write_reg(pcrc_pkg::REG_ROBOT_TRANS, 64'd0);
		write_reg(pcrc_pkg::REG_BOX_XY, {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
		write_reg(pcrc_pkg::REG_BOX_Z, {16'sh7FFF, 16'sh8000});
		write_reg(pcrc_pkg::REG_CLEARANCE, 64'd0);
		hold_cycles = 300;
		for (int i = 0; i < 60; i++) send_point(rand_pt(8000), 1'b1);
		drain();
	endtask

	initial begin
		robot_rot = 64'd16384; map_rot = 64'd16384;
		robot_trans = '0; map_trans = '0;
		box_xy = '0; box_z = '0; clearance = 15'd450;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_defaults();
		test_directed();
		random_phase(450, 0, 0);
		random_phase(450, 67, 0);
		random_phase(450, 0, 67);
		random_phase(350, 10, 10);
		test_backpressure();
		if (errors == 0 && exp_wr == exp_rd)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
